// ===== design/line_rasterizer_defines.svh =====
// Assertion macros for the line rasterizer checker
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

// checked only outside reset
`define LR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define LR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== design/lr_pkg.sv =====
// Types, constants and helpers shared by the line rasterizer
package lr_pkg;

   localparam int COORD_BITS  = 12;
   localparam int ERR_BITS    = COORD_BITS + 2;
   localparam int COLOR_BITS  = 32;
   localparam int OFFSET_BITS = 28;
   localparam int PITCH_BITS  = 16;
   localparam int BPP_BITS    = 3;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CSR_IDX_BITS-1:0] CSR_ROW_PITCH = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BPP       = 1'd1;

   localparam logic [PITCH_BITS-1:0] PITCH_RESET = 16'd2560;
   localparam logic [BPP_BITS-1:0]   BPP_RESET   = 3'd4;

   typedef enum logic {
      REQ_START = 1'b0,
      REQ_TICK  = 1'b1
   } req_kind_type;

   typedef struct packed {
      req_kind_type          kind;
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic [COORD_BITS-1:0] end_x;
      logic [COORD_BITS-1:0] end_y;
      logic [COLOR_BITS-1:0] color;
   } req_item_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COLOR_BITS-1:0] color;
      logic                  last;
   } pixel_type;

   function automatic logic [COORD_BITS-1:0] step_coord(input logic [COORD_BITS-1:0] v,
                                                        input logic neg);
      step_coord = neg ? v - COORD_BITS'(1) : v + COORD_BITS'(1);
   endfunction

   function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
      abs_diff = (a > b) ? a - b : b - a;
   endfunction

endpackage

// ===== design/lr_channels.sv =====
// Request and response channel interfaces of the line rasterizer

interface lr_req_if import lr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  req_type;
   logic [COORD_BITS-1:0] start_x;
   logic [COORD_BITS-1:0] start_y;
   logic [COORD_BITS-1:0] end_x;
   logic [COORD_BITS-1:0] end_y;
   logic [COLOR_BITS-1:0] line_color;

   modport source (output valid, req_type, start_x, start_y, end_x, end_y, line_color,
                   input ready);
   modport sink   (input valid, req_type, start_x, start_y, end_x, end_y, line_color,
                   output ready);
endinterface

interface lr_rsp_if import lr_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [COORD_BITS-1:0]  pixel_x;
   logic [COORD_BITS-1:0]  pixel_y;
   logic [OFFSET_BITS-1:0] byte_offset;
   logic [COLOR_BITS-1:0]  pixel_value;
   logic                   last_pixel;

   modport source (output valid, pixel_x, pixel_y, byte_offset, pixel_value, last_pixel,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, byte_offset, pixel_value, last_pixel,
                   output ready);
endinterface

// ===== design/line_rasterizer.sv =====
// Line rasterizer top level: channels, register port and offset stage
// A tick's pixel is registered in the pixel stage, then in the offset stage.
// Throughput: one request per cycle, start or tick, while no stage stalls;
//   Bresenham step: one add and compare; offset: 12x16 plus 12x3 multiply.
// Reset: synchronous; clears the line (idle), empties both stages and loads
//   row pitch 2560 and 4 bytes per pixel.
module line_rasterizer import lr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   lr_req_if.sink                   req_bus,
   lr_rsp_if.source                 rsp_bus,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   logic [PITCH_BITS-1:0] pitch_ff, pitch_in;
   logic [BPP_BITS-1:0]   bpp_ff, bpp_in;
   logic [CSR_IDX_BITS-1:0] csr_idx;
   logic                  csr_wr;

   logic                  s1_valid_ff, s1_valid_in;
   pixel_type             s1_pix_ff, s1_pix_in;
   logic                  out_valid_ff, out_valid_in;
   pixel_type             out_pix_ff;
   logic [OFFSET_BITS-1:0] out_off_ff, off_calc;

   logic                  fire, emit, s1_move;
   req_item_type          item;
   pixel_type             pix;

   // register port
   assign pready  = 1'b1;
   assign csr_idx = paddr[CSR_ADDR_BITS-1:2];
   assign csr_wr  = psel && penable && pwrite;

   always_comb begin
      pitch_in = pitch_ff;
      bpp_in   = bpp_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            CSR_ROW_PITCH: pitch_in = pwdata[PITCH_BITS-1:0];
            CSR_BPP:       bpp_in   = pwdata[BPP_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_ROW_PITCH: prdata = CSR_DATA_BITS'(pitch_ff);
         CSR_BPP:       prdata = CSR_DATA_BITS'(bpp_ff);
         default:       prdata = '0;
      endcase
   end

   // request side
   assign item.kind    = req_kind_type'(req_bus.req_type);
   assign item.start_x = req_bus.start_x;
   assign item.start_y = req_bus.start_y;
   assign item.end_x   = req_bus.end_x;
   assign item.end_y   = req_bus.end_y;
   assign item.color   = req_bus.line_color;

   assign s1_move       = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_move;
   assign fire          = req_bus.valid && req_bus.ready;

   lr_walker u_walker (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (item),
      .emit  (emit),
      .pix   (pix)
   );

   // pixel stage
   always_comb begin
      s1_valid_in = s1_valid_ff && !s1_move;
      s1_pix_in   = s1_pix_ff;
      if (emit) begin
         s1_valid_in = 1'b1;
         s1_pix_in   = pix;
      end
   end

   // offset stage
   assign off_calc = OFFSET_BITS'(s1_pix_ff.y) * OFFSET_BITS'(pitch_ff)
                   + OFFSET_BITS'(s1_pix_ff.x) * OFFSET_BITS'(bpp_ff);

   assign out_valid_in = s1_move || (out_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff     <= PITCH_RESET;
         bpp_ff       <= BPP_RESET;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pitch_ff     <= pitch_in;
         bpp_ff       <= bpp_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pix_ff <= s1_pix_in;
      if (s1_move) begin
         out_pix_ff <= s1_pix_ff;
         out_off_ff <= off_calc;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.pixel_x     = out_pix_ff.x;
   assign rsp_bus.pixel_y     = out_pix_ff.y;
   assign rsp_bus.byte_offset = out_off_ff;
   assign rsp_bus.pixel_value = out_pix_ff.color;
   assign rsp_bus.last_pixel  = out_pix_ff.last;

endmodule

// ===== design/lr_walker.sv =====
// Bresenham line state: loads a line on start, steps one pixel per tick while pixels are left
module lr_walker import lr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   output logic         emit,
   output pixel_type    pix
);

   logic [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic [ERR_BITS-1:0]   err_ff, err_in;
   logic [COORD_BITS-1:0] dx_ff, dx_in;
   logic [COORD_BITS-1:0] dy_ff, dy_in;
   logic                  dxn_ff, dxn_in;
   logic                  dyn_ff, dyn_in;
   logic                  xmaj_ff, xmaj_in;
   logic [COORD_BITS-1:0] left_ff, left_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;

   logic [COORD_BITS-1:0] major, minor, s_dx, s_dy, s_major;
   logic [ERR_BITS-1:0]   err_sum;
   logic                  minor_step;
   logic [COORD_BITS-1:0] tick_x, tick_y;
   logic                  busy;

   assign busy    = (left_ff != '0);
   assign major   = xmaj_ff ? dx_ff : dy_ff;
   assign minor   = xmaj_ff ? dy_ff : dx_ff;
   assign err_sum = err_ff + ERR_BITS'(minor);
   assign minor_step = (err_sum > ERR_BITS'(major));

   always_comb begin
      tick_x = cur_x_ff;
      tick_y = cur_y_ff;
      if (xmaj_ff || minor_step) begin
         tick_x = step_coord(cur_x_ff, dxn_ff);
      end
      if (!xmaj_ff || minor_step) begin
         tick_y = step_coord(cur_y_ff, dyn_ff);
      end
   end

   assign s_dx    = abs_diff(item.start_x, item.end_x);
   assign s_dy    = abs_diff(item.start_y, item.end_y);
   assign s_major = (s_dx > s_dy) ? s_dx : s_dy;

   assign emit = fire && (item.kind == REQ_TICK) && busy;

   assign pix.x     = tick_x;
   assign pix.y     = tick_y;
   assign pix.color = color_ff;
   assign pix.last  = (left_ff == COORD_BITS'(1));

   always_comb begin
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      err_in   = err_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      dxn_in   = dxn_ff;
      dyn_in   = dyn_ff;
      xmaj_in  = xmaj_ff;
      left_in  = left_ff;
      color_in = color_ff;
      if (fire && item.kind == REQ_START) begin
         cur_x_in = item.start_x;
         cur_y_in = item.start_y;
         dx_in    = s_dx;
         dy_in    = s_dy;
         dxn_in   = !(item.start_x < item.end_x);
         dyn_in   = !(item.start_y < item.end_y);
         xmaj_in  = (s_dx > s_dy);
         err_in   = ERR_BITS'(s_major >> 1);
         left_in  = s_major;
         color_in = item.color;
      end else if (emit) begin
         cur_x_in = tick_x;
         cur_y_in = tick_y;
         err_in   = minor_step ? err_sum - ERR_BITS'(major) : err_sum;
         left_in  = left_ff - COORD_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff <= '0;
         cur_y_ff <= '0;
         err_ff   <= '0;
         dx_ff    <= '0;
         dy_ff    <= '0;
         dxn_ff   <= 1'b0;
         dyn_ff   <= 1'b0;
         xmaj_ff  <= 1'b0;
         left_ff  <= '0;
         color_ff <= '0;
      end else begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         err_ff   <= err_in;
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         dxn_ff   <= dxn_in;
         dyn_ff   <= dyn_in;
         xmaj_ff  <= xmaj_in;
         left_ff  <= left_in;
         color_ff <= color_in;
      end
   end

endmodule

// ===== design/lr_checker.sv =====
// Port-level checker for the line rasterizer, bound to the top level
`include "line_rasterizer_defines.svh"

module lr_checker import lr_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [COORD_BITS-1:0]  pixel_x,
   input logic [COORD_BITS-1:0]  pixel_y,
   input logic [OFFSET_BITS-1:0] byte_offset,
   input logic                   last_pixel
);

   property p_rsp_hold;
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pixel_x) && $stable(pixel_y)
         && $stable(byte_offset) && $stable(last_pixel);
   endproperty

   `LR_ASSERT_ALWAYS(a_rsp_empty_after_reset, reset |=> !rsp_valid, "response valid after reset")
   `LR_ASSERT(a_ready_when_rsp_free, !rsp_valid |-> req_ready, "request stalled with free output")
   `LR_ASSERT(a_rsp_hold, p_rsp_hold, "stalled response changed")

endmodule

bind line_rasterizer lr_checker u_lr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .pixel_x     (rsp_bus.pixel_x),
   .pixel_y     (rsp_bus.pixel_y),
   .byte_offset (rsp_bus.byte_offset),
   .last_pixel  (rsp_bus.last_pixel)
);
